// ----- rtl/core/bse_pkg.sv -----
// shared constants for the early-exit bubble sort core
`default_nettype none
package bse_pkg;
	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;
endpackage
`default_nettype wire

// ----- rtl/core/bubble_sort_early_exit_core.sv -----
// streaming bubble sort core with early exit, one shared compare unit
//
// channel  signals                                   direction
// in       in_valid in_ready value last              into the core
// out      out_valid out_ready sorted_value          out of the core
//          last_out overflow
//
// loading takes one cycle per transaction; in_ready is high only while loading.
// a set of n elements sorts in passes over the first len elements, len = n, n-1, ...,
// stopping after the first pass without a swap or once fewer than two remain.
// each pass streams the element store through one read port and one write port,
// carrying the running maximum in a register against one signed comparator.
// one result read is in flight at a time; a stalled out_ready holds the sequencer.
// reset clears the counters and the sequencer; the element store is not cleared.
`default_nettype none
module bubble_sort_early_exit_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic signed [bse_pkg::DATA_W-1:0] value,
	input  wire logic                  last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [bse_pkg::DATA_W-1:0] sorted_value,
	output logic                       last_out,
	output logic                       overflow
);
	import bse_pkg::*;

	state_t state_q;
	cnt_t   cnt_q;
	logic   drop_q;
	cnt_t   len_q;
	cnt_t   rd_idx_q;
	logic   swap_q;
	data_t  held_q;
	logic   rv_s1;
	addr_t  idx_s1;
	cnt_t   e_q;
	logic   rpend_q;
	logic   elast_s1;
	logic   ovalid_q;
	data_t  odata_q;
	logic   olast_q;
	logic   oovf_q;

	logic   ram_we;
	addr_t  ram_waddr;
	data_t  ram_wdata;
	addr_t  ram_raddr;
	data_t  ram_rdata;

	logic   in_acc;
	logic   full;
	cnt_t   n_next;
	logic   scan_issue;
	logic   emit_issue;
	logic   gt;
	logic   scan_end;
	cnt_t   len_dec;

	assign in_ready   = (state_q == ST_LOAD);
	assign in_acc     = in_valid && in_ready;
	assign full       = (cnt_q == CNT_W'(MAX_ITEMS));
	assign n_next     = full ? cnt_q : cnt_q + CNT_W'(1);
	assign len_dec    = len_q - CNT_W'(1);
	assign scan_issue = (state_q == ST_SCAN) && (rd_idx_q < len_q);
	assign emit_issue = (state_q == ST_EMIT) && (e_q < cnt_q) && !rpend_q
		&& (!ovalid_q || out_ready);
	// held value is the running maximum of the pass
	assign gt         = $signed(held_q) > $signed(ram_rdata);
	assign scan_end   = rv_s1 && ({1'b0, idx_s1} == len_dec);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[ADDR_W-1:0];
		ram_wdata = value;
		case (state_q)
			ST_LOAD: begin
				ram_we = in_acc && !full;
			end
			ST_SCAN: begin
				ram_we    = rv_s1 && (idx_s1 != '0);
				ram_waddr = idx_s1 - ADDR_W'(1);
				ram_wdata = gt ? ram_rdata : held_q;
			end
			ST_FLUSH: begin
				ram_we    = 1'b1;
				ram_waddr = len_dec[ADDR_W-1:0];
				ram_wdata = held_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign ram_raddr = (state_q == ST_EMIT) ? e_q[ADDR_W-1:0] : rd_idx_q[ADDR_W-1:0];

	bse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
			len_q    <= '0;
			rd_idx_q <= '0;
			swap_q   <= 1'b0;
			rv_s1    <= 1'b0;
			e_q      <= '0;
			rpend_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			rv_s1   <= scan_issue;
			rpend_q <= emit_issue;
			if (scan_issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (emit_issue) begin
				e_q <= e_q + CNT_W'(1);
			end
			if (rpend_q) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q  <= n_next;
						drop_q <= drop_q | full;
						if (last) begin
							len_q    <= n_next;
							rd_idx_q <= '0;
							swap_q   <= 1'b0;
							e_q      <= '0;
							state_q  <= (n_next >= CNT_W'(2)) ? ST_SCAN : ST_EMIT;
						end
					end
				end
				ST_SCAN: begin
					if (rv_s1 && (idx_s1 != '0) && gt) begin
						swap_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					len_q    <= len_dec;
					rd_idx_q <= '0;
					swap_q   <= 1'b0;
					if (!swap_q || (len_dec < CNT_W'(2))) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (rpend_q && elast_s1) begin
						cnt_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= rd_idx_q[ADDR_W-1:0];
		elast_s1 <= (e_q == cnt_q - CNT_W'(1));
		if (rv_s1) begin
			if (idx_s1 == '0) begin
				held_q <= ram_rdata;
			end else if (!gt) begin
				held_q <= ram_rdata;
			end
		end
		if (rpend_q) begin
			odata_q <= ram_rdata;
			olast_q <= elast_s1;
			oovf_q  <= drop_q;
		end
	end

	assign out_valid    = ovalid_q;
	assign sorted_value = odata_q;
	assign last_out     = olast_q;
	assign overflow     = oovf_q;
endmodule
`default_nettype wire

// ----- rtl/core/bse_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module bse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
